[hw/rtl/mts_pkg.sv]
// Shared types and constants for the min-tracking stack.
// Used by the channel interfaces, the stack RAM and the core; depends on nothing.
package mts_pkg;

  localparam int DataWidth    = 32;
  localparam int CountWidth   = 11;
  localparam int DefaultDepth = 1024;

  localparam logic signed [DataWidth-1:0] EmptyMinReset = 32'sh7FFF_FFFF;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_POP   = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH2,
    S_POP_CHK,
    S_POP_MIN,
    S_PEEK,
    S_RESP
  } state_e;

endpackage

[hw/rtl/mts_if.sv]
// Valid/ready channel interfaces for stack requests and responses.
// Depends on mts_pkg for the action and status codes.
interface mts_req_if;
  logic                                 valid;
  logic                                 ready;
  mts_pkg::action_e                     action;
  logic signed [mts_pkg::DataWidth-1:0] push_value;

  modport source (output valid, output action, output push_value, input ready);
  modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface mts_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mts_pkg::DataWidth-1:0] result_value;
  logic signed [mts_pkg::DataWidth-1:0] current_min;
  logic [mts_pkg::CountWidth-1:0]       entry_count;
  mts_pkg::status_e                     status;

  modport source (output valid, output result_value, output current_min,
                  output entry_count, output status, input ready);
  modport sink   (input valid, input result_value, input current_min,
                  input entry_count, input status, output ready);
endinterface

[hw/rtl/mts_ram.sv]
// Single-port stack RAM with a registered read.
// Depends on mts_pkg for the word width.
module mts_ram #(
  parameter int DEPTH = mts_pkg::DefaultDepth,
  parameter int AddrW = $clog2(DEPTH)
) (
  input  logic                                 clk_i,
  input  logic                                 en_i,
  input  logic                                 we_i,
  input  logic [AddrW-1:0]                     addr_i,
  input  logic signed [mts_pkg::DataWidth-1:0] wdata_i,
  output logic signed [mts_pkg::DataWidth-1:0] rdata_o
);

  logic signed [mts_pkg::DataWidth-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[addr_i] <= wdata_i;
      end else begin
        rdata_o <= mem[addr_i];
      end
    end
  end

endmodule

[hw/rtl/min_tracking_stack_core.sv]
// Min-tracking stack core: sequencer, running minimum and response register.
// Depends on mts_pkg, mts_req_if, mts_rsp_if and mts_ram.
//
// A LIFO of signed 32-bit words that answers every request with the popped or
// top value (else zero), the current minimum, the number of memory words in use
// and a status. A push of a value not above the minimum first saves the old
// minimum in the stack, so a push takes one or two words; a pop that removes
// the minimum also removes the saved word and restores it. All words live in
// one single-port RAM with a registered read: a push writes in S_IDLE and, when
// it saves the old minimum, again in S_PUSH2; a peek reads in S_IDLE and takes
// the word in S_PEEK; a pop reads in S_IDLE, checks it in S_POP_CHK and restores
// a saved minimum in S_POP_MIN; a clear, a refused push or an access to an empty
// stack ends in S_IDLE. Results leave through an output register, so a new
// request is taken while the last response waits; the sequencer only stalls when
// a second response is ready before the first one is taken. The empty_min register
// supplies the minimum reported while the stack is empty and takes effect at once.
module min_tracking_stack_core #(
  parameter int DEPTH = mts_pkg::DefaultDepth
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  mts_req_if.sink                              req_i,
  mts_rsp_if.source                            rsp_o,
  input  logic                                 empty_min_we_i,
  input  logic signed [mts_pkg::DataWidth-1:0] empty_min_i
);

  localparam int DW    = mts_pkg::DataWidth;
  localparam int CntW  = mts_pkg::CountWidth;
  localparam int AddrW = $clog2(DEPTH);
  localparam int PtrW  = $clog2(DEPTH + 1);
  localparam int PtrW1 = PtrW + 1;
  localparam logic [PtrW1-1:0] DepthWords = PtrW1'(DEPTH);

  mts_pkg::state_e state_q, state_d;

  logic [PtrW-1:0]        top_q, top_d;
  logic signed [DW-1:0]   min_q, min_d;
  logic signed [DW-1:0]   empty_min_q;
  logic signed [DW-1:0]   val_q, val_d;
  logic signed [DW-1:0]   res_q, res_d;
  mts_pkg::status_e       status_q, status_d;

  logic                   out_valid_q, out_valid_d;
  logic signed [DW-1:0]   out_value_q, out_min_q;
  logic [CntW-1:0]        out_count_q;
  mts_pkg::status_e       out_status_q;

  logic                   mem_en, mem_we;
  logic [AddrW-1:0]       mem_addr;
  logic signed [DW-1:0]   mem_wdata, mem_rdata;

  logic                   accept, out_free, finish, load_out;
  logic                   new_min, push_full, is_empty, pop_again;
  logic [PtrW-1:0]        top_m1;
  logic [PtrW1-1:0]       need_top;

  mts_ram #(
    .DEPTH (DEPTH),
    .AddrW (AddrW)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (mem_en),
    .we_i    (mem_we),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  assign req_i.ready = (state_q == mts_pkg::S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;
  assign load_out    = finish && out_free;

  assign new_min   = (req_i.push_value <= min_q);
  assign need_top  = {1'b0, top_q} + (new_min ? PtrW1'(2) : PtrW1'(1));
  assign push_full = (need_top > DepthWords);
  assign is_empty  = (top_q == '0);
  assign top_m1    = top_q - PtrW'(1);
  // The word just read equals the minimum, so it carried a saved minimum below it.
  assign pop_again = (mem_rdata == min_q) && !is_empty;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mts_pkg::S_IDLE: begin
        if (accept) begin
          unique case (req_i.action)
            mts_pkg::ACT_PUSH: begin
              if (!push_full && new_min) begin
                state_d = mts_pkg::S_PUSH2;
              end else begin
                state_d = out_free ? mts_pkg::S_IDLE : mts_pkg::S_RESP;
              end
            end
            mts_pkg::ACT_POP: begin
              if (is_empty) begin
                state_d = out_free ? mts_pkg::S_IDLE : mts_pkg::S_RESP;
              end else begin
                state_d = mts_pkg::S_POP_CHK;
              end
            end
            mts_pkg::ACT_PEEK: begin
              if (is_empty) begin
                state_d = out_free ? mts_pkg::S_IDLE : mts_pkg::S_RESP;
              end else begin
                state_d = mts_pkg::S_PEEK;
              end
            end
            mts_pkg::ACT_CLEAR: begin
              state_d = out_free ? mts_pkg::S_IDLE : mts_pkg::S_RESP;
            end
          endcase
        end
      end
      mts_pkg::S_POP_CHK: begin
        if (pop_again) begin
          state_d = mts_pkg::S_POP_MIN;
        end else begin
          state_d = out_free ? mts_pkg::S_IDLE : mts_pkg::S_RESP;
        end
      end
      mts_pkg::S_PUSH2,
      mts_pkg::S_POP_MIN,
      mts_pkg::S_PEEK,
      mts_pkg::S_RESP: begin
        state_d = out_free ? mts_pkg::S_IDLE : mts_pkg::S_RESP;
      end
      default: state_d = mts_pkg::S_IDLE;
    endcase
  end

  // Memory access, stack state and response fields.
  always_comb begin
    mem_en    = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = top_q[AddrW-1:0];
    mem_wdata = req_i.push_value;
    top_d     = top_q;
    min_d     = min_q;
    val_d     = val_q;
    res_d     = res_q;
    status_d  = status_q;
    finish    = 1'b0;

    unique case (state_q)
      mts_pkg::S_IDLE: begin
        if (accept) begin
          res_d    = '0;
          status_d = mts_pkg::STAT_OK;
          unique case (req_i.action)
            mts_pkg::ACT_PUSH: begin
              if (push_full) begin
                status_d = mts_pkg::STAT_FULL;
                finish   = 1'b1;
              end else begin
                mem_en = 1'b1;
                mem_we = 1'b1;
                top_d  = top_q + PtrW'(1);
                if (new_min) begin
                  // Save the old minimum first; the value follows next cycle.
                  mem_wdata = min_q;
                  min_d     = req_i.push_value;
                  val_d     = req_i.push_value;
                end else begin
                  finish = 1'b1;
                end
              end
            end
            mts_pkg::ACT_POP,
            mts_pkg::ACT_PEEK: begin
              if (is_empty) begin
                status_d = mts_pkg::STAT_EMPTY;
                finish   = 1'b1;
              end else begin
                mem_en   = 1'b1;
                mem_addr = top_m1[AddrW-1:0];
                if (req_i.action == mts_pkg::ACT_POP) begin
                  top_d = top_m1;
                end
              end
            end
            mts_pkg::ACT_CLEAR: begin
              top_d  = '0;
              min_d  = empty_min_q;
              finish = 1'b1;
            end
          endcase
        end
      end
      mts_pkg::S_PUSH2: begin
        mem_en    = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = val_q;
        top_d     = top_q + PtrW'(1);
        finish    = 1'b1;
      end
      mts_pkg::S_POP_CHK: begin
        res_d = mem_rdata;
        if (pop_again) begin
          mem_en   = 1'b1;
          mem_addr = top_m1[AddrW-1:0];
          top_d    = top_m1;
        end else begin
          if (is_empty) begin
            min_d = empty_min_q;
          end
          finish = 1'b1;
        end
      end
      mts_pkg::S_POP_MIN: begin
        min_d  = is_empty ? empty_min_q : mem_rdata;
        finish = 1'b1;
      end
      mts_pkg::S_PEEK: begin
        res_d  = mem_rdata;
        finish = 1'b1;
      end
      mts_pkg::S_RESP: begin
        finish = 1'b1;
      end
      default: begin
        finish = 1'b0;
      end
    endcase

    // A new empty minimum shows at once while the stack holds nothing.
    if (empty_min_we_i && is_empty) begin
      min_d = empty_min_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mts_pkg::S_IDLE;
      top_q       <= '0;
      min_q       <= mts_pkg::EmptyMinReset;
      empty_min_q <= mts_pkg::EmptyMinReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      min_q       <= min_d;
      out_valid_q <= out_valid_d;
      if (empty_min_we_i) begin
        empty_min_q <= empty_min_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    val_q    <= val_d;
    res_q    <= res_d;
    status_q <= status_d;
    if (load_out) begin
      out_value_q  <= res_d;
      out_min_q    <= min_d;
      out_count_q  <= CntW'(top_d);
      out_status_q <= status_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.result_value = out_value_q;
  assign rsp_o.current_min  = out_min_q;
  assign rsp_o.entry_count  = out_count_q;
  assign rsp_o.status       = out_status_q;

`ifndef SYNTHESIS
  a_top_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, top_q} <= DepthWords)
    else $error("stack pointer beyond depth");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_en && mem_we) |-> ({1'b0, top_q} < DepthWords))
    else $error("stack write beyond depth");

  a_empty_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mts_pkg::S_IDLE && is_empty) |-> (min_q == empty_min_q))
    else $error("empty stack reports a stale minimum");

  a_resp_only_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != mts_pkg::S_RESP && state_d == mts_pkg::S_RESP) |-> !out_free)
    else $error("response held back with a free output register");

  a_pop_min_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mts_pkg::S_POP_MIN) |-> ($past(state_q) == mts_pkg::S_POP_CHK))
    else $error("saved minimum read without a preceding pop check");
`endif

endmodule
